@@ rtl/pssu_pkg.sv @@
`default_nettype none

package pssu_pkg;

    // Field widths.
    localparam int TIMER_BITS = 12;
    localparam int VOLT_BITS  = 11;
    localparam int CFG_IDX_BITS = 3;

    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [VOLT_BITS-1:0]  t_volt;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_timer TIMER_MAX = {TIMER_BITS{1'b1}};

    // Configuration register indexes.
    localparam t_cfg_idx CFG_TEST_MODE       = 3'd0;
    localparam t_cfg_idx CFG_DC_READY_LEVEL  = 3'd1;
    localparam t_cfg_idx CFG_PRECHARGE_TICKS = 3'd2;
    localparam t_cfg_idx CFG_MAIN_TICKS      = 3'd3;
    localparam t_cfg_idx CFG_DC_RISE_TICKS   = 3'd4;
    localparam t_cfg_idx CFG_RECT_TICKS      = 3'd5;
    localparam t_cfg_idx CFG_INV_TICKS       = 3'd6;

    // Configuration reset values.
    localparam t_volt  RST_DC_READY_LEVEL  = 11'd700;
    localparam t_timer RST_PRECHARGE_TICKS = 12'd100;
    localparam t_timer RST_MAIN_TICKS      = 12'd100;
    localparam t_timer RST_DC_RISE_TICKS   = 12'd2000;
    localparam t_timer RST_RECT_TICKS      = 12'd200;
    localparam t_timer RST_INV_TICKS       = 12'd200;

    // Reported system status codes.
    localparam logic [1:0] ST_STOP   = 2'd0;
    localparam logic [1:0] ST_CHARGE = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FAULT  = 2'd3;

    // Pre-charge stage phases.
    typedef enum logic [5:0] {
        CH_DISCHARGED = 6'b000001,
        CH_PRE_WAIT   = 6'b000010,
        CH_RISING     = 6'b000100,
        CH_MAIN_WAIT  = 6'b001000,
        CH_MAIN_OK    = 6'b010000,
        CH_CHARGED    = 6'b100000
    } t_charge_phase;

    // Rectifier stage phases.
    typedef enum logic [3:0] {
        RC_STOP  = 4'b0001,
        RC_READY = 4'b0010,
        RC_WAIT  = 4'b0100,
        RC_RUN   = 4'b1000
    } t_rect_phase;

    // Inverter stage phases.
    typedef enum logic [4:0] {
        IV_STOP       = 5'b00001,
        IV_READY_WAIT = 5'b00010,
        IV_READY      = 5'b00100,
        IV_START_WAIT = 5'b01000,
        IV_RUN        = 5'b10000
    } t_inv_phase;

    // One step of an on-delay counter: count up and stick at full scale.
    function automatic t_timer sat_inc(input t_timer cnt);
        t_timer res;
        res = (cnt == TIMER_MAX) ? cnt : cnt + t_timer'(1);
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/power_stage_startup_sequencer.sv @@
`default_nettype none

// Start-up sequencer for a three-stage power converter (DC-link pre-charge,
// rectifier, inverter with bypass), advanced by one tick per input transfer.
// Each tick carries the fault flag, run commands, DC-link voltage and contactor
// feedback; each tick produces exactly one result transfer with the contactor,
// enable and controller-on commands and the held system status. A tick is
// registered on arrival in the input register and evaluated from there into
// the state registers, which present its result; a new tick can be taken
// every cycle while the result side does not stall.
// The command and status state registers themselves form the result register;
// a stalled result holds them, which in turn holds back the input side once the
// input register is full. Configuration registers are written through a port
// that is always ready and should only be written while no tick is in flight.
module power_stage_startup_sequencer (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Configuration write channel.
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  pssu_pkg::t_cfg_idx     i_cfg_index,
    input  wire  pssu_pkg::t_timer       i_cfg_data,
    // Tick input channel.
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_heavy_fault,
    input  wire                          i_all_enable,
    input  wire  [2:0]                   i_unit_enables,
    input  wire  pssu_pkg::t_volt        i_dc_link_v,
    input  wire                          i_precharge_fb,
    input  wire                          i_main_fb,
    // Result output channel.
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_precharge_close,
    output logic                         o_main_close,
    output logic                         o_bypass_closed,
    output logic                         o_conv_enable,
    output logic                         o_inv_enable,
    output logic                         o_dc_loop_on,
    output logic                         o_ac_loop_on,
    output logic                         o_charge_ok,
    output logic [1:0]                   o_system_status,
    output logic                         o_system_run
);
    import pssu_pkg::*;

    // Configuration registers.
    logic   r_test_mode;
    t_volt  r_dc_ready_level;
    t_timer r_pre_ticks, r_main_ticks, r_rise_ticks, r_rect_ticks, r_inv_ticks;

    // Input register.
    logic       r_s1_valid;
    logic       r_s1_hf, r_s1_all, r_s1_pre_fb, r_s1_main_fb;
    logic [2:0] r_s1_units;
    t_volt      r_s1_volts;

    // Sequencer state, which also forms the result register.
    logic          r_out_valid;
    t_charge_phase r_ch, n_ch;
    t_rect_phase   r_rc, n_rc;
    t_inv_phase    r_iv, n_iv;
    logic          r_ch_run, n_ch_run, r_rc_run, n_rc_run;
    logic [2:0]    r_armed, n_armed;
    t_timer        r_cnt_pre, n_cnt_pre, r_cnt_main, n_cnt_main, r_cnt_rise, n_cnt_rise;
    t_timer        r_cnt_rect, n_cnt_rect, r_cnt_inv, n_cnt_inv;
    logic          r_c_pre, n_c_pre, r_c_main, n_c_main, r_c_byp, n_c_byp;
    logic          r_c_conv, n_c_conv, r_c_inv, n_c_inv, r_c_dcl, n_c_dcl;
    logic          r_c_acl, n_c_acl, r_c_chok, n_c_chok;
    logic [1:0]    r_status, n_status;
    logic          r_run_held, n_run_held;

    // Handshake control.
    logic in_xfer, adv;

    // Counter steps and their expiry checks.
    t_timer inc_pre, inc_main, inc_rise, inc_rect, inc_inv;
    logic   done_pre, done_main, done_rise, done_rect, done_inv;

    // Decoded tick conditions.
    logic tm, act_c, act_r, act_i, all_do, all_stop, volt_ok, rect_cmd;
    logic stop_c, stop_r, stop_i;

    // The tick in the input register advances when the result slot is free.
    assign adv         = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !adv;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_mode      <= 1'b0;
            r_dc_ready_level <= RST_DC_READY_LEVEL;
            r_pre_ticks      <= RST_PRECHARGE_TICKS;
            r_main_ticks     <= RST_MAIN_TICKS;
            r_rise_ticks     <= RST_DC_RISE_TICKS;
            r_rect_ticks     <= RST_RECT_TICKS;
            r_inv_ticks      <= RST_INV_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TEST_MODE:       r_test_mode      <= i_cfg_data[0];
                CFG_DC_READY_LEVEL:  r_dc_ready_level <= i_cfg_data[VOLT_BITS-1:0];
                CFG_PRECHARGE_TICKS: r_pre_ticks      <= i_cfg_data;
                CFG_MAIN_TICKS:      r_main_ticks     <= i_cfg_data;
                CFG_DC_RISE_TICKS:   r_rise_ticks     <= i_cfg_data;
                CFG_RECT_TICKS:      r_rect_ticks     <= i_cfg_data;
                CFG_INV_TICKS:       r_inv_ticks      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_hf      <= i_heavy_fault;
            r_s1_all     <= i_all_enable;
            r_s1_units   <= i_unit_enables;
            r_s1_volts   <= i_dc_link_v;
            r_s1_pre_fb  <= i_precharge_fb;
            r_s1_main_fb <= i_main_fb;
        end
    end

    // Counter steps, each counter steps at most once per tick.
    always_comb begin
        inc_pre   = sat_inc(r_cnt_pre);
        inc_main  = sat_inc(r_cnt_main);
        inc_rise  = sat_inc(r_cnt_rise);
        inc_rect  = sat_inc(r_cnt_rect);
        inc_inv   = sat_inc(r_cnt_inv);
        done_pre  = inc_pre  >= r_pre_ticks;
        done_main = inc_main >= r_main_ticks;
        done_rise = inc_rise >= r_rise_ticks;
        done_rect = inc_rect >= r_rect_ticks;
        done_inv  = inc_inv  >= r_inv_ticks;
    end

    // Next state for one tick: pre-charge, then rectifier, then inverter,
    // then the held status, each seeing the stage updates made before it.
    always_comb begin
        tm       = r_test_mode;
        act_c    = r_s1_units[0];
        act_r    = r_s1_units[1];
        act_i    = r_s1_units[2];
        all_do   = !tm && r_s1_all;
        all_stop = !tm && !r_s1_all;
        volt_ok  = r_s1_volts >= r_dc_ready_level;

        n_ch       = r_ch;
        n_rc       = r_rc;
        n_iv       = r_iv;
        n_ch_run   = r_ch_run;
        n_rc_run   = r_rc_run;
        n_armed    = r_armed;
        n_cnt_pre  = r_cnt_pre;
        n_cnt_main = r_cnt_main;
        n_cnt_rise = r_cnt_rise;
        n_cnt_rect = r_cnt_rect;
        n_cnt_inv  = r_cnt_inv;
        n_c_pre    = r_c_pre;
        n_c_main   = r_c_main;
        n_c_byp    = r_c_byp;
        n_c_conv   = r_c_conv;
        n_c_inv    = r_c_inv;
        n_c_dcl    = r_c_dcl;
        n_c_acl    = r_c_acl;
        n_c_chok   = r_c_chok;
        n_status   = r_status;
        n_run_held = r_run_held;

        // Pre-charge stage.
        stop_c = r_s1_hf || (tm && !act_c) || all_stop;
        if (stop_c) begin
            if (r_ch != CH_DISCHARGED) begin
                n_ch_run = 1'b0;
                n_c_main = 1'b0;
                n_c_pre  = 1'b0;
                n_ch     = CH_DISCHARGED;
                n_c_chok = 1'b0;
            end
        end else begin
            case (r_ch)
                CH_DISCHARGED: begin
                    n_armed[0] = 1'b1;
                    if (volt_ok) begin
                        n_c_main   = 1'b1;
                        n_cnt_main = '0;
                        n_ch       = CH_MAIN_WAIT;
                    end else begin
                        n_c_pre   = 1'b1;
                        n_cnt_pre = '0;
                        n_ch      = CH_PRE_WAIT;
                    end
                end
                CH_PRE_WAIT: begin
                    if (!r_armed[0] || r_s1_pre_fb) begin
                        n_cnt_rise = '0;
                        n_armed[0] = 1'b1;
                        n_ch       = CH_RISING;
                    end else begin
                        n_cnt_pre = inc_pre;
                        if (done_pre) begin
                            n_c_pre    = 1'b0;
                            n_armed[0] = 1'b0;
                            n_ch       = CH_DISCHARGED;
                        end
                    end
                end
                CH_RISING: begin
                    if (r_armed[0]) begin
                        n_cnt_rise = inc_rise;
                        if (done_rise) begin
                            n_armed[0] = 1'b0;
                            n_c_pre    = 1'b0;
                            n_ch       = CH_DISCHARGED;
                        end else if (volt_ok) begin
                            n_c_pre    = 1'b0;
                            n_c_main   = 1'b1;
                            n_cnt_main = '0;
                            n_ch       = CH_MAIN_WAIT;
                        end
                    end
                end
                CH_MAIN_WAIT: begin
                    n_cnt_main = inc_main;
                    if (done_main) begin
                        n_c_pre    = 1'b0;
                        n_c_main   = 1'b0;
                        n_armed[0] = 1'b0;
                        n_ch       = CH_DISCHARGED;
                    end else if (r_s1_main_fb) begin
                        n_armed[0] = 1'b0;
                        n_ch       = CH_MAIN_OK;
                    end
                end
                CH_MAIN_OK: begin
                    n_ch     = CH_CHARGED;
                    n_ch_run = 1'b1;
                    n_c_chok = 1'b1;
                end
                CH_CHARGED: begin
                    // Main breaker lost: wait for it again, charge_ok is kept.
                    if (!r_s1_main_fb) begin
                        n_cnt_main = '0;
                        n_armed[0] = 1'b1;
                        n_ch       = CH_MAIN_WAIT;
                        n_ch_run   = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        // Rectifier stage.
        stop_r = r_s1_hf || (tm && !act_r) || all_stop || (all_do && !n_ch_run);
        if (stop_r) begin
            n_rc       = RC_STOP;
            n_armed[1] = 1'b0;
            n_rc_run   = 1'b0;
            n_c_dcl    = 1'b0;
            n_c_conv   = 1'b0;
        end else begin
            case (r_rc)
                RC_STOP: n_rc = RC_READY;
                RC_READY: begin
                    n_cnt_rect = '0;
                    n_armed[1] = 1'b1;
                    n_rc       = RC_WAIT;
                end
                RC_WAIT: begin
                    if (r_armed[1]) begin
                        n_cnt_rect = inc_rect;
                        if (done_rect) begin
                            n_armed[1] = 1'b0;
                            n_rc       = RC_RUN;
                            n_rc_run   = 1'b1;
                            n_c_dcl    = 1'b1;
                            n_c_conv   = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Inverter stage; the ready delay and the start delay share a counter.
        stop_i = r_s1_hf || (tm && !act_i) || (!tm && (!r_s1_all || !n_rc_run));
        if (stop_i) begin
            if (r_iv != IV_STOP) begin
                n_iv       = IV_STOP;
                n_armed[2] = 1'b0;
                n_c_acl    = 1'b0;
                n_c_inv    = 1'b0;
                n_c_byp    = 1'b1;
            end
        end else begin
            case (r_iv)
                IV_STOP: begin
                    n_cnt_inv  = '0;
                    n_armed[2] = 1'b1;
                    n_iv       = IV_READY_WAIT;
                end
                IV_READY_WAIT: begin
                    if (r_armed[2]) begin
                        n_cnt_inv = inc_inv;
                        if (done_inv) begin
                            n_iv       = IV_READY;
                            n_armed[2] = 1'b0;
                        end
                    end
                end
                IV_READY: begin
                    n_c_acl    = 1'b1;
                    n_cnt_inv  = '0;
                    n_armed[2] = 1'b1;
                    n_iv       = IV_START_WAIT;
                end
                IV_START_WAIT: begin
                    if (r_armed[2]) begin
                        n_cnt_inv = inc_inv;
                        if (done_inv) begin
                            n_iv       = IV_RUN;
                            n_armed[2] = 1'b0;
                            n_c_byp    = 1'b0;
                            n_c_inv    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Held system status, from the phases after this tick.
        rect_cmd = (tm && act_r) || all_do;
        if (n_ch == CH_RISING) begin
            n_status   = ST_CHARGE;
            n_run_held = 1'b0;
        end else if (n_ch == CH_CHARGED) begin
            if (n_rc_run) begin
                n_status   = ST_RUN;
                n_run_held = 1'b1;
            end
        end else if (n_ch == CH_DISCHARGED) begin
            n_run_held = 1'b0;
            if (r_s1_hf) begin
                n_status = ST_FAULT;
            end else if (!rect_cmd) begin
                n_status = ST_STOP;
            end
        end else begin
            n_run_held = 1'b0;
        end
        if (n_rc == RC_STOP) begin
            if (r_s1_hf) begin
                n_status = ST_FAULT;
            end else if (!rect_cmd) begin
                n_status = ST_STOP;
            end
        end else if (n_rc == RC_RUN) begin
            n_status = ST_RUN;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer state, updated once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch       <= CH_DISCHARGED;
            r_rc       <= RC_STOP;
            r_iv       <= IV_STOP;
            r_ch_run   <= 1'b0;
            r_rc_run   <= 1'b0;
            r_armed    <= '0;
            r_cnt_pre  <= '0;
            r_cnt_main <= '0;
            r_cnt_rise <= '0;
            r_cnt_rect <= '0;
            r_cnt_inv  <= '0;
            r_c_pre    <= 1'b0;
            r_c_main   <= 1'b0;
            r_c_byp    <= 1'b1;
            r_c_conv   <= 1'b0;
            r_c_inv    <= 1'b0;
            r_c_dcl    <= 1'b0;
            r_c_acl    <= 1'b0;
            r_c_chok   <= 1'b0;
            r_status   <= ST_STOP;
            r_run_held <= 1'b0;
        end else if (adv) begin
            r_ch       <= n_ch;
            r_rc       <= n_rc;
            r_iv       <= n_iv;
            r_ch_run   <= n_ch_run;
            r_rc_run   <= n_rc_run;
            r_armed    <= n_armed;
            r_cnt_pre  <= n_cnt_pre;
            r_cnt_main <= n_cnt_main;
            r_cnt_rise <= n_cnt_rise;
            r_cnt_rect <= n_cnt_rect;
            r_cnt_inv  <= n_cnt_inv;
            r_c_pre    <= n_c_pre;
            r_c_main   <= n_c_main;
            r_c_byp    <= n_c_byp;
            r_c_conv   <= n_c_conv;
            r_c_inv    <= n_c_inv;
            r_c_dcl    <= n_c_dcl;
            r_c_acl    <= n_c_acl;
            r_c_chok   <= n_c_chok;
            r_status   <= n_status;
            r_run_held <= n_run_held;
        end
    end

    // Result fields come straight from the state registers.
    assign o_out_valid       = r_out_valid;
    assign o_precharge_close = r_c_pre;
    assign o_main_close      = r_c_main;
    assign o_bypass_closed   = r_c_byp;
    assign o_conv_enable     = r_c_conv;
    assign o_inv_enable      = r_c_inv;
    assign o_dc_loop_on      = r_c_dcl;
    assign o_ac_loop_on      = r_c_acl;
    assign o_charge_ok       = r_c_chok;
    assign o_system_status   = r_status;
    assign o_system_run      = r_run_held;

    // The inverter PWM and the bypass are never commanded on together.
    a_inv_bypass_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_inv |-> !r_c_byp)
        else $error("inverter enabled while bypass is closed");

    // The rectifier run flag and its controller commands follow its run phase.
    a_rect_run_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rc == RC_RUN) == (r_rc_run && r_c_conv && r_c_dcl))
        else $error("rectifier run flag disagrees with its phase");

    // The inverter enable is set exactly in the inverter run phase.
    a_inv_run_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iv == IV_RUN) == r_c_inv)
        else $error("inverter enable disagrees with its phase");

    // A stalled result freezes the sequencer.
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=>
            ($stable(r_ch) && $stable(r_rc) && $stable(r_iv) && $stable(r_status)))
        else $error("sequencer advanced while its result was stalled");

endmodule

`default_nettype wire

@@ tb/startup_seq_checker.sv @@
`timescale 1ns / 1ps

// Watches the configuration, tick and result channels of the start-up sequencer.
// Every tick transfer is run through a cycle-free model of the three stages, and
// the command word it yields is queued until the matching result transfer arrives.
module startup_seq_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  pssu_pkg::t_cfg_idx   i_cfg_index,
    input  pssu_pkg::t_timer     i_cfg_data,
    input  wire                  i_in_valid,
    input  wire                  i_in_stall,
    input  wire                  i_heavy_fault,
    input  wire                  i_all_enable,
    input  wire  [2:0]           i_unit_enables,
    input  pssu_pkg::t_volt      i_dc_link_v,
    input  wire                  i_precharge_fb,
    input  wire                  i_main_fb,
    input  wire                  i_out_valid,
    input  wire                  i_out_stall,
    input  wire                  i_precharge_close,
    input  wire                  i_main_close,
    input  wire                  i_bypass_closed,
    input  wire                  i_conv_enable,
    input  wire                  i_inv_enable,
    input  wire                  i_dc_loop_on,
    input  wire                  i_ac_loop_on,
    input  wire                  i_charge_ok,
    input  wire  [1:0]           i_system_status,
    input  wire                  i_system_run,
    output int                   o_fail_count,
    output int                   o_pending
);
    import pssu_pkg::*;

    // On-delay counter slots.
    localparam int TMR_PRE  = 0;
    localparam int TMR_MAIN = 1;
    localparam int TMR_RISE = 2;
    localparam int TMR_RECT = 3;
    localparam int TMR_INV  = 4;

    // Stage slots of the armed flags.
    localparam int ARM_CHG  = 0;
    localparam int ARM_RECT = 1;
    localparam int ARM_INV  = 2;

    typedef struct packed {
        logic       heavy_fault;
        logic       all_enable;
        logic [2:0] unit_enables;
        t_volt      dc_link_v;
        logic       precharge_fb;
        logic       main_fb;
    } t_tick;

    typedef struct packed {
        logic       precharge_close;
        logic       main_close;
        logic       bypass_closed;
        logic       conv_enable;
        logic       inv_enable;
        logic       dc_loop_on;
        logic       ac_loop_on;
        logic       charge_ok;
        logic [1:0] system_status;
        logic       system_run;
    } t_cmd;

    // Configuration copy.
    logic   cfg_test_mode;
    t_volt  cfg_ready_level;
    t_timer cfg_pre_ticks;
    t_timer cfg_main_ticks;
    t_timer cfg_rise_ticks;
    t_timer cfg_rect_ticks;
    t_timer cfg_inv_ticks;

    // Sequencer state copy.
    t_charge_phase chg_phase;
    t_rect_phase   rect_phase;
    t_inv_phase    inv_phase;
    logic          chg_running;
    logic          rect_running;
    logic [2:0]    armed;
    t_timer        delay_cnt [5];
    t_cmd          cmd;

    t_cmd expected_cmds [$];
    int   fail_cnt = 0;
    int   outstanding = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = outstanding;

    function automatic void clear_model();
        cfg_test_mode   = 1'b0;
        cfg_ready_level = RST_DC_READY_LEVEL;
        cfg_pre_ticks   = RST_PRECHARGE_TICKS;
        cfg_main_ticks  = RST_MAIN_TICKS;
        cfg_rise_ticks  = RST_DC_RISE_TICKS;
        cfg_rect_ticks  = RST_RECT_TICKS;
        cfg_inv_ticks   = RST_INV_TICKS;
        chg_phase    = CH_DISCHARGED;
        rect_phase   = RC_STOP;
        inv_phase    = IV_STOP;
        chg_running  = 1'b0;
        rect_running = 1'b0;
        armed        = '0;
        foreach (delay_cnt[k]) delay_cnt[k] = '0;
        cmd               = '0;
        cmd.bypass_closed = 1'b1;
        cmd.system_status = ST_STOP;
    endfunction

    // Advance one on-delay counter, sticking at full scale, and report expiry.
    function automatic logic timer_done(input int slot, input t_timer ticks);
        if (delay_cnt[slot] != TIMER_MAX) begin
            delay_cnt[slot] = delay_cnt[slot] + t_timer'(1);
        end
        return delay_cnt[slot] >= ticks;
    endfunction

    // Apply one tick to the model; returns the command word that follows.
    function automatic t_cmd sequence_tick(input t_tick t);
        logic tm;
        logic want_chg;
        logic want_rect;
        logic want_inv;
        logic run_all;
        logic stop_all;
        logic volt_ok;
        logic rect_cmd;
        tm        = cfg_test_mode;
        want_chg  = t.unit_enables[0];
        want_rect = t.unit_enables[1];
        want_inv  = t.unit_enables[2];
        run_all   = !tm && t.all_enable;
        stop_all  = !tm && !t.all_enable;
        volt_ok   = t.dc_link_v >= cfg_ready_level;

        // Pre-charge stage.
        if (t.heavy_fault || (tm && !want_chg) || stop_all) begin
            if (chg_phase != CH_DISCHARGED) begin
                chg_running         = 1'b0;
                cmd.main_close      = 1'b0;
                cmd.precharge_close = 1'b0;
                cmd.charge_ok       = 1'b0;
                chg_phase           = CH_DISCHARGED;
            end
        end else begin
            case (chg_phase)
                CH_DISCHARGED: begin
                    if (volt_ok) begin
                        cmd.main_close      = 1'b1;
                        delay_cnt[TMR_MAIN] = '0;
                        chg_phase           = CH_MAIN_WAIT;
                    end else begin
                        cmd.precharge_close = 1'b1;
                        delay_cnt[TMR_PRE]  = '0;
                        chg_phase           = CH_PRE_WAIT;
                    end
                    armed[ARM_CHG] = 1'b1;
                end
                CH_PRE_WAIT: begin
                    if (!armed[ARM_CHG] || t.precharge_fb) begin
                        delay_cnt[TMR_RISE] = '0;
                        armed[ARM_CHG]      = 1'b1;
                        chg_phase           = CH_RISING;
                    end else if (timer_done(TMR_PRE, cfg_pre_ticks)) begin
                        cmd.precharge_close = 1'b0;
                        armed[ARM_CHG]      = 1'b0;
                        chg_phase           = CH_DISCHARGED;
                    end
                end
                CH_RISING: begin
                    if (armed[ARM_CHG]) begin
                        if (timer_done(TMR_RISE, cfg_rise_ticks)) begin
                            armed[ARM_CHG]      = 1'b0;
                            cmd.precharge_close = 1'b0;
                            chg_phase           = CH_DISCHARGED;
                        end else if (volt_ok) begin
                            cmd.precharge_close = 1'b0;
                            cmd.main_close      = 1'b1;
                            delay_cnt[TMR_MAIN] = '0;
                            chg_phase           = CH_MAIN_WAIT;
                        end
                    end
                end
                CH_MAIN_WAIT: begin
                    // The counter moves first, so feedback on the expiry tick is too late.
                    if (timer_done(TMR_MAIN, cfg_main_ticks)) begin
                        cmd.precharge_close = 1'b0;
                        cmd.main_close      = 1'b0;
                        armed[ARM_CHG]      = 1'b0;
                        chg_phase           = CH_DISCHARGED;
                    end else if (t.main_fb) begin
                        armed[ARM_CHG] = 1'b0;
                        chg_phase      = CH_MAIN_OK;
                    end
                end
                CH_MAIN_OK: begin
                    chg_phase     = CH_CHARGED;
                    chg_running   = 1'b1;
                    cmd.charge_ok = 1'b1;
                end
                CH_CHARGED: begin
                    // Losing the breaker goes back to waiting with the close command held.
                    if (!t.main_fb) begin
                        delay_cnt[TMR_MAIN] = '0;
                        armed[ARM_CHG]      = 1'b1;
                        chg_phase           = CH_MAIN_WAIT;
                        chg_running         = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        // Rectifier stage.
        if (t.heavy_fault || (tm && !want_rect) || stop_all || (run_all && !chg_running)) begin
            rect_phase      = RC_STOP;
            armed[ARM_RECT] = 1'b0;
            rect_running    = 1'b0;
            cmd.dc_loop_on  = 1'b0;
            cmd.conv_enable = 1'b0;
        end else begin
            case (rect_phase)
                RC_STOP: rect_phase = RC_READY;
                RC_READY: begin
                    delay_cnt[TMR_RECT] = '0;
                    armed[ARM_RECT]     = 1'b1;
                    rect_phase          = RC_WAIT;
                end
                RC_WAIT: begin
                    if (armed[ARM_RECT]) begin
                        if (timer_done(TMR_RECT, cfg_rect_ticks)) begin
                            armed[ARM_RECT] = 1'b0;
                            rect_phase      = RC_RUN;
                            rect_running    = 1'b1;
                            cmd.dc_loop_on  = 1'b1;
                            cmd.conv_enable = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Inverter stage with its bypass switch.
        if (t.heavy_fault || (tm && !want_inv) || (!tm && (!t.all_enable || !rect_running))) begin
            if (inv_phase != IV_STOP) begin
                inv_phase         = IV_STOP;
                armed[ARM_INV]    = 1'b0;
                cmd.ac_loop_on    = 1'b0;
                cmd.inv_enable    = 1'b0;
                cmd.bypass_closed = 1'b1;
            end
        end else begin
            case (inv_phase)
                IV_STOP: begin
                    delay_cnt[TMR_INV] = '0;
                    armed[ARM_INV]     = 1'b1;
                    inv_phase          = IV_READY_WAIT;
                end
                IV_READY_WAIT: begin
                    if (armed[ARM_INV]) begin
                        if (timer_done(TMR_INV, cfg_inv_ticks)) begin
                            inv_phase      = IV_READY;
                            armed[ARM_INV] = 1'b0;
                        end
                    end
                end
                IV_READY: begin
                    cmd.ac_loop_on     = 1'b1;
                    delay_cnt[TMR_INV] = '0;
                    armed[ARM_INV]     = 1'b1;
                    inv_phase          = IV_START_WAIT;
                end
                IV_START_WAIT: begin
                    if (armed[ARM_INV]) begin
                        if (timer_done(TMR_INV, cfg_inv_ticks)) begin
                            inv_phase         = IV_RUN;
                            armed[ARM_INV]    = 1'b0;
                            cmd.bypass_closed = 1'b0;
                            cmd.inv_enable    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Held status: the charger view first, then the rectifier overrides it.
        rect_cmd = (tm && want_rect) || run_all;
        if (chg_phase == CH_RISING) begin
            cmd.system_status = ST_CHARGE;
            cmd.system_run    = 1'b0;
        end else if (chg_phase == CH_CHARGED) begin
            if (rect_running) begin
                cmd.system_status = ST_RUN;
                cmd.system_run    = 1'b1;
            end
        end else if (chg_phase == CH_DISCHARGED) begin
            cmd.system_run = 1'b0;
            if (t.heavy_fault) begin
                cmd.system_status = ST_FAULT;
            end else if (!rect_cmd) begin
                cmd.system_status = ST_STOP;
            end
        end else begin
            cmd.system_run = 1'b0;
        end
        if (rect_phase == RC_STOP) begin
            if (t.heavy_fault) begin
                cmd.system_status = ST_FAULT;
            end else if (!rect_cmd) begin
                cmd.system_status = ST_STOP;
            end
        end else if (rect_phase == RC_RUN) begin
            cmd.system_status = ST_RUN;
        end
        return cmd;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Channel monitor: result transfers are checked before a new tick is queued.
    always @(posedge i_clk) begin : monitor
        t_cmd  want;
        t_tick t;
        if (!i_rst_n) begin
            clear_model();
            expected_cmds.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEST_MODE:       cfg_test_mode   = i_cfg_data[0];
                    CFG_DC_READY_LEVEL:  cfg_ready_level = i_cfg_data[VOLT_BITS-1:0];
                    CFG_PRECHARGE_TICKS: cfg_pre_ticks   = i_cfg_data;
                    CFG_MAIN_TICKS:      cfg_main_ticks  = i_cfg_data;
                    CFG_DC_RISE_TICKS:   cfg_rise_ticks  = i_cfg_data;
                    CFG_RECT_TICKS:      cfg_rect_ticks  = i_cfg_data;
                    CFG_INV_TICKS:       cfg_inv_ticks   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_cmds.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    fail_cnt++;
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("precharge_close", 32'(want.precharge_close),
                                32'(i_precharge_close));
                    check_field("main_close", 32'(want.main_close), 32'(i_main_close));
                    check_field("bypass_closed", 32'(want.bypass_closed),
                                32'(i_bypass_closed));
                    check_field("conv_enable", 32'(want.conv_enable), 32'(i_conv_enable));
                    check_field("inv_enable", 32'(want.inv_enable), 32'(i_inv_enable));
                    check_field("dc_loop_on", 32'(want.dc_loop_on), 32'(i_dc_loop_on));
                    check_field("ac_loop_on", 32'(want.ac_loop_on), 32'(i_ac_loop_on));
                    check_field("charge_ok", 32'(want.charge_ok), 32'(i_charge_ok));
                    check_field("system_status", 32'(want.system_status),
                                32'(i_system_status));
                    check_field("system_run", 32'(want.system_run), 32'(i_system_run));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                t.heavy_fault  = i_heavy_fault;
                t.all_enable   = i_all_enable;
                t.unit_enables = i_unit_enables;
                t.dc_link_v    = i_dc_link_v;
                t.precharge_fb = i_precharge_fb;
                t.main_fb      = i_main_fb;
                expected_cmds.push_back(sequence_tick(t));
            end
        end
        outstanding = expected_cmds.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus for the start-up sequencer: a short directed opening, two extreme-setting
// sessions, then random start-up sessions mixed with noise ticks under changing configurations.
module testbench;
    import pssu_pkg::*;

    localparam int TOTAL_TICKS   = 440;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 200000;
    localparam t_cfg_idx CFG_SPARE_IDX = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    t_cfg_idx   cfg_index;
    t_timer     cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       heavy_fault;
    logic       all_enable;
    logic [2:0] unit_enables;
    t_volt      dc_link_v;
    logic       precharge_fb;
    logic       main_fb;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       precharge_close;
    logic       main_close;
    logic       bypass_closed;
    logic       conv_enable;
    logic       inv_enable;
    logic       dc_loop_on;
    logic       ac_loop_on;
    logic       charge_ok;
    logic [1:0] system_status;
    logic       system_run;

    int    fail_count;
    int    pending;
    int    send_idle_pct = 17;
    int    recv_idle_pct = 47;
    int    ticks_sent = 0;
    int    cycle_cnt = 0;
    logic  cur_test_mode = 1'b0;
    t_volt cur_level = RST_DC_READY_LEVEL;

    power_stage_startup_sequencer dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_heavy_fault     (heavy_fault),
        .i_all_enable      (all_enable),
        .i_unit_enables    (unit_enables),
        .i_dc_link_v       (dc_link_v),
        .i_precharge_fb    (precharge_fb),
        .i_main_fb         (main_fb),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_precharge_close (precharge_close),
        .o_main_close      (main_close),
        .o_bypass_closed   (bypass_closed),
        .o_conv_enable     (conv_enable),
        .o_inv_enable      (inv_enable),
        .o_dc_loop_on      (dc_loop_on),
        .o_ac_loop_on      (ac_loop_on),
        .o_charge_ok       (charge_ok),
        .o_system_status   (system_status),
        .o_system_run      (system_run)
    );

    startup_seq_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_heavy_fault     (heavy_fault),
        .i_all_enable      (all_enable),
        .i_unit_enables    (unit_enables),
        .i_dc_link_v       (dc_link_v),
        .i_precharge_fb    (precharge_fb),
        .i_main_fb         (main_fb),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_precharge_close (precharge_close),
        .i_main_close      (main_close),
        .i_bypass_closed   (bypass_closed),
        .i_conv_enable     (conv_enable),
        .i_inv_enable      (inv_enable),
        .i_dc_loop_on      (dc_loop_on),
        .i_ac_loop_on      (ac_loop_on),
        .i_charge_ok       (charge_ok),
        .i_system_status   (system_status),
        .i_system_run      (system_run),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // One tick transfer, after a random gap; returns at the falling edge after it.
    task automatic send_tick(input logic hf, input logic all_en, input logic [2:0] units,
                             input t_volt volts, input logic pre_fb, input logic mn_fb);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        heavy_fault  <= hf;
        all_enable   <= all_en;
        unit_enables <= units;
        dc_link_v    <= volts;
        precharge_fb <= pre_fb;
        main_fb      <= mn_fb;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic send_noise();
        send_tick(1'($urandom), 1'($urandom), 3'($urandom), t_volt'($urandom),
                  1'($urandom), 1'($urandom));
    endtask

    // Stop sending and wait until every result transfer has come out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input t_timer val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Rewrite the whole register set while the block is idle.
    task automatic configure(input logic tm, input t_volt level, input t_timer pre,
                             input t_timer mn, input t_timer rise, input t_timer rect,
                             input t_timer inv);
        wait_idle();
        put_reg(CFG_TEST_MODE, t_timer'(tm));
        put_reg(CFG_DC_READY_LEVEL, t_timer'(level));
        put_reg(CFG_PRECHARGE_TICKS, pre);
        put_reg(CFG_MAIN_TICKS, mn);
        put_reg(CFG_DC_RISE_TICKS, rise);
        put_reg(CFG_RECT_TICKS, rect);
        put_reg(CFG_INV_TICKS, inv);
        // An unused index must leave every register alone.
        put_reg(CFG_SPARE_IDX, t_timer'($urandom));
        cfg_valid     <= 1'b0;
        cur_test_mode = tm;
        cur_level     = level;
    endtask

    task automatic configure_random();
        t_volt  level;
        t_timer mn;
        case ($urandom_range(3))
            0:       level = '0;
            1:       level = '1;
            default: level = t_volt'($urandom);
        endcase
        mn = ($urandom_range(3) == 0) ? t_timer'($urandom_range(1, 4095))
                                      : t_timer'($urandom_range(1, 6));
        configure(1'($urandom), level, t_timer'($urandom_range(1, 6)), mn,
                  t_timer'($urandom_range(1, 12)), t_timer'($urandom_range(1, 5)),
                  t_timer'($urandom_range(1, 5)));
    endtask

    // A start-up attempt: feedback and voltage arrive at random ticks, with rare
    // faults, enable drops and breaker losses, and the session ends in a stop.
    task automatic run_session(input int unsigned len);
        int unsigned pfb_at;
        int unsigned rise_at;
        int unsigned mfb_at;
        int unsigned drop_at;
        logic [2:0]  units;
        t_volt       volts;
        logic        hf;
        logic        all_en;
        pfb_at  = $urandom_range(0, 4);
        rise_at = $urandom_range(1, 10);
        mfb_at  = rise_at + $urandom_range(0, 4);
        drop_at = $urandom_range(mfb_at + 2, len + 10);
        units   = ($urandom_range(3) == 0) ? 3'($urandom) : 3'b111;
        for (int unsigned i = 0; i < len; i++) begin
            if (i >= rise_at || cur_level == '0) begin
                volts = t_volt'($urandom_range(cur_level, 2047));
            end else begin
                volts = t_volt'($urandom_range(0, cur_level - 1));
            end
            hf     = ($urandom_range(99) < 2);
            all_en = ($urandom_range(99) >= 3);
            send_tick(hf, all_en, units, volts, (i >= pfb_at),
                      (i >= mfb_at) && (i != drop_at));
        end
        if ($urandom_range(1) == 0) begin
            send_tick(1'b1, 1'($urandom), 3'($urandom), t_volt'($urandom),
                      1'($urandom), 1'($urandom));
        end else begin
            send_tick(1'b0, 1'b0, cur_test_mode ? 3'b000 : 3'($urandom),
                      t_volt'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        heavy_fault  <= 1'b0;
        all_enable   <= 1'b0;
        unit_enables <= '0;
        dc_link_v    <= '0;
        precharge_fb <= 1'b0;
        main_fb      <= 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening with short waits.
        configure(1'b0, 11'd100, 12'd2, 12'd2, 12'd3, 12'd1, 12'd1);
        send_tick(1'b0, 1'b0, 3'b000, 11'd0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 3'b111, 11'd2047, 1'b1, 1'b1);
        // Breaker feedback on the very tick its wait runs out is a failure.
        send_tick(1'b0, 1'b1, 3'b000, 11'd2047, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 3'b000, 11'd2047, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 3'b000, 11'd2047, 1'b0, 1'b1);
        // Pre-charge closes but the link never rises in time.
        send_tick(1'b0, 1'b1, 3'b000, 11'd0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 3'b000, 11'd0, 1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b1, 3'b000, 11'd99, 1'b1, 1'b0);
        // Full start-up, then the main breaker drops out while charged.
        send_tick(1'b0, 1'b1, 3'b000, 11'd0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 3'b000, 11'd50, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 3'b000, 11'd100, 1'b1, 1'b0);
        repeat (7) send_tick(1'b0, 1'b1, 3'b000, 11'd800, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 3'b000, 11'd800, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 3'b000, 11'd800, 1'b1, 1'b1);
        // Test mode: rectifier without a charged link, inverter without a rectifier.
        configure(1'b1, 11'd100, 12'd2, 12'd2, 12'd3, 12'd1, 12'd1);
        repeat (4) send_tick(1'b0, 1'b0, 3'b100, 11'd0, 1'b0, 1'b0);
        repeat (4) send_tick(1'b0, 1'b0, 3'b010, 11'd0, 1'b0, 1'b0);

        // Extreme settings.
        configure(1'b0, 11'd2047, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        run_session(20);
        configure(1'b1, 11'd0, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
        run_session(20);

        // Random part: mostly well-formed sessions, some noise bursts.
        while (ticks_sent < TOTAL_TICKS) begin
            if (ticks_sent < TOTAL_TICKS / 3) begin
                send_idle_pct = 17;
                recv_idle_pct = 47;
            end else if (ticks_sent < 2 * TOTAL_TICKS / 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(5) == 0) begin
                configure_random();
            end
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 8)) send_noise();
            end else begin
                run_session($urandom_range(15, 45));
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/pssu_pkg.sv
rtl/power_stage_startup_sequencer.sv
tb/startup_seq_checker.sv
tb/testbench.sv
